>>> sv/vpts_pkg.sv
package vpts_pkg;

	// Clip values are exact sums of four 32x32 products.
	localparam int CW = 67;
	// Offset sums (x+w, w-y) are nonnegative and below 2^66.
	localparam int SW = 67;
	// Divisor (positive w).
	localparam int DW = 66;
	// Viewport size width.
	localparam int VW = 13;
	// Dividend: offset sum times size times 128.
	localparam int NW = 88;
	// Quotient width: result is at most size * 256.
	localparam int QW = 21;
	// Split point of the offset sum for the scaling multiply.
	localparam int SPLIT = 34;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	localparam logic [2:0] REG_MAT_X_A = 3'd0;
	localparam logic [2:0] REG_MAT_X_B = 3'd1;
	localparam logic [2:0] REG_MAT_Y_A = 3'd2;
	localparam logic [2:0] REG_MAT_Y_B = 3'd3;
	localparam logic [2:0] REG_MAT_W_A = 3'd4;
	localparam logic [2:0] REG_MAT_W_B = 3'd5;
	localparam logic [2:0] REG_WIDTH   = 3'd6;
	localparam logic [2:0] REG_HEIGHT  = 3'd7;

	typedef struct packed {
		logic [63:0] mat_x_a;
		logic [63:0] mat_x_b;
		logic [63:0] mat_y_a;
		logic [63:0] mat_y_b;
		logic [63:0] mat_w_a;
		logic [63:0] mat_w_b;
		logic [VW-1:0] width;
		logic [VW-1:0] height;
	} cfg_t;

	// One classified point travelling from the front to the back.
	typedef struct packed {
		logic on_screen;
		logic [SW-1:0] sum_x;
		logic [SW-1:0] sum_y;
		logic [DW-1:0] w;
	} item_t;

endpackage

>>> sv/vpts_front.sv
module vpts_front import vpts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic en,
	input  logic in_valid,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_y,
	input  logic signed [31:0] world_z,
	output logic out_valid,
	output item_t out_item
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [63:0] px_s1 [3];
	logic signed [63:0] py_s1 [3];
	logic signed [63:0] pw_s1 [3];
	logic signed [CW-1:0] xa_s2, xb_s2, ya_s2, yb_s2, wa_s2, wb_s2;
	logic signed [CW-1:0] cx_s3, cy_s3, cw_s3;
	item_t item_s4;
	logic signed [CW-1:0] ncx, ncy, c3x, c3y, c3w;
	logic w_pos, in_view;

	// Column 3 meets the implied 1.0 coordinate, which is a plain shift.
	assign c3x = CW'($signed({cfg.mat_x_b[63:32], 16'h0000}));
	assign c3y = CW'($signed({cfg.mat_y_b[63:32], 16'h0000}));
	assign c3w = CW'($signed({cfg.mat_w_b[63:32], 16'h0000}));

	// Stage 1: nine products, one multiplier each.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1[0] <= $signed(cfg.mat_x_a[31:0]) * world_x;
			px_s1[1] <= $signed(cfg.mat_x_a[63:32]) * world_y;
			px_s1[2] <= $signed(cfg.mat_x_b[31:0]) * world_z;
			py_s1[0] <= $signed(cfg.mat_y_a[31:0]) * world_x;
			py_s1[1] <= $signed(cfg.mat_y_a[63:32]) * world_y;
			py_s1[2] <= $signed(cfg.mat_y_b[31:0]) * world_z;
			pw_s1[0] <= $signed(cfg.mat_w_a[31:0]) * world_x;
			pw_s1[1] <= $signed(cfg.mat_w_a[63:32]) * world_y;
			pw_s1[2] <= $signed(cfg.mat_w_b[31:0]) * world_z;
		end
	end

	// Stage 2: pairwise sums.
	always_ff @(posedge clk) begin
		if (en) begin
			xa_s2 <= CW'(px_s1[0]) + CW'(px_s1[1]);
			xb_s2 <= CW'(px_s1[2]) + c3x;
			ya_s2 <= CW'(py_s1[0]) + CW'(py_s1[1]);
			yb_s2 <= CW'(py_s1[2]) + c3y;
			wa_s2 <= CW'(pw_s1[0]) + CW'(pw_s1[1]);
			wb_s2 <= CW'(pw_s1[2]) + c3w;
		end
	end

	// Stage 3: clip coordinates.
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3 <= xa_s2 + xb_s2;
			cy_s3 <= ya_s2 + yb_s2;
			cw_s3 <= wa_s2 + wb_s2;
		end
	end

	// Stage 4: visibility test and the offsets used by the viewport scale.
	assign ncx = -cx_s3;
	assign ncy = -cy_s3;
	assign w_pos = !cw_s3[CW-1] && (cw_s3 != '0);
	assign in_view = !(cx_s3 > cw_s3) && !(ncx > cw_s3) && !(cy_s3 > cw_s3) && !(ncy > cw_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4.on_screen <= w_pos && in_view;
			item_s4.sum_x <= SW'(cx_s3 + cw_s3);
			item_s4.sum_y <= SW'(cw_s3 - cy_s3);
			item_s4.w <= cw_s3[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_item = item_s4;

endmodule

>>> sv/vpts_fifo.sv
module vpts_fifo import vpts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  item_t push_item,
	input  logic pop,
	output logic full,
	output logic empty,
	output item_t pop_item
);

	item_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0] count_q;

	assign full = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign pop_item = mem_q[rd_q];

	// Storage is written only at the write pointer.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/vpts_back.sv
module vpts_back import vpts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [VW-1:0] width,
	input  logic [VW-1:0] height,
	input  logic en,
	input  logic in_valid,
	input  item_t in_item,
	output logic out_valid,
	output logic on_screen,
	output logic [QW-1:0] screen_x,
	output logic [QW-1:0] screen_y
);

	logic v_s1;
	logic on_s1;
	logic [DW-1:0] w_s1;
	logic [SPLIT+VW-1:0] xlo_s1, ylo_s1;
	logic [SW-SPLIT+VW-1:0] xhi_s1, yhi_s1;

	// Divider pipeline: entry 0 holds the dividend, entry j+1 the result of step j.
	logic v_sd [QW+1];
	logic on_sd [QW+1];
	logic [DW-1:0] d_sd [QW+1];
	logic [NW-1:0] rx_sd [QW+1];
	logic [NW-1:0] ry_sd [QW+1];
	logic [QW-1:0] qx_sd [QW+1];
	logic [QW-1:0] qy_sd [QW+1];

	logic v_q, on_q;
	logic [QW-1:0] sx_q, sy_q;

	// Scale by the viewport size, split in two narrow multiplies.
	always_ff @(posedge clk) begin
		if (en) begin
			on_s1 <= in_item.on_screen;
			w_s1 <= in_item.w;
			xlo_s1 <= in_item.sum_x[SPLIT-1:0] * width;
			xhi_s1 <= in_item.sum_x[SW-1:SPLIT] * width;
			ylo_s1 <= in_item.sum_y[SPLIT-1:0] * height;
			yhi_s1 <= in_item.sum_y[SW-1:SPLIT] * height;
		end
	end

	// Recombine the partial products and apply the factor 128.
	always_ff @(posedge clk) begin
		if (en) begin
			on_sd[0] <= on_s1;
			d_sd[0] <= w_s1;
			rx_sd[0] <= ((NW'(xhi_s1) << SPLIT) + NW'(xlo_s1)) << 7;
			ry_sd[0] <= ((NW'(yhi_s1) << SPLIT) + NW'(ylo_s1)) << 7;
			qx_sd[0] <= '0;
			qy_sd[0] <= '0;
		end
	end

	// One quotient bit per step, most significant first.
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [NW:0] tx, ty;
		logic [NW-1:0] dsh;

		assign dsh = NW'(d_sd[j]) << (QW - 1 - j);
		assign tx = {1'b0, rx_sd[j]} - {1'b0, dsh};
		assign ty = {1'b0, ry_sd[j]} - {1'b0, dsh};

		always_ff @(posedge clk) begin
			if (en) begin
				on_sd[j+1] <= on_sd[j];
				d_sd[j+1] <= d_sd[j];
				rx_sd[j+1] <= tx[NW] ? rx_sd[j] : tx[NW-1:0];
				ry_sd[j+1] <= ty[NW] ? ry_sd[j] : ty[NW-1:0];
				qx_sd[j+1] <= qx_sd[j] | (QW'(!tx[NW]) << (QW - 1 - j));
				qy_sd[j+1] <= qy_sd[j] | (QW'(!ty[NW]) << (QW - 1 - j));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[j+1] <= 1'b0;
			end else if (en) begin
				v_sd[j+1] <= v_sd[j];
			end
		end
	end

	// Output register; off-screen points report zero coordinates.
	always_ff @(posedge clk) begin
		if (en) begin
			on_q <= on_sd[QW];
			sx_q <= on_sd[QW] ? qx_sd[QW] : '0;
			sy_q <= on_sd[QW] ? qy_sd[QW] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_sd[0] <= 1'b0;
			v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_sd[0] <= v_s1;
			v_q <= v_sd[QW];
		end
	end

	assign out_valid = v_q;
	assign on_screen = on_q;
	assign screen_x = sx_q;
	assign screen_y = sy_q;

endmodule

>>> sv/vertex_project_to_screen.sv
// Projects world points to screen pixel positions.
// Input stream: one request carries world_x, world_y and world_z, each a
// signed Q16.16 value, packed in s_axis_tdata from the low bits up.
// Output stream: one request per input, in order; m_axis_tdata holds
// screen_x and screen_y (unsigned Q13.8), m_axis_tuser holds on_screen.
// Points behind the camera or outside the view give zero coordinates.
// Configuration: cfg_index selects one of the eight registers (matrix rows
// x, y, w in two halves each, then viewport width and height); writes are
// always taken and must only happen while no point is in flight.
// Throughput is one point per cycle while the receiver does not stall. An
// accepted input passes the matrix transform and classification, the queue,
// the viewport scaling and 21 steps of a pipelined restoring divider, one per
// quotient bit, and then the output register.
// When the receiver stalls, the back pipeline holds; the four-entry queue
// absorbs the front, which stops taking input once the queue is full.
// Reset clears all valid flags and the queue and loads the identity
// projection with a 640 by 480 viewport.
module vertex_project_to_screen import vpts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [95:0] s_axis_tdata, // world_x, world_y, world_z
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // screen_x, screen_y, zero fill
	output logic m_axis_tuser, // on_screen
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t cfg_q;
	logic front_en, back_en;
	logic f_valid;
	item_t f_item, q_item;
	logic q_full, q_empty, q_push, q_pop;
	logic [QW-1:0] sx, sy;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mat_x_a <= 64'd65536;
			cfg_q.mat_x_b <= 64'd0;
			cfg_q.mat_y_a <= 64'd65536 << 32;
			cfg_q.mat_y_b <= 64'd0;
			cfg_q.mat_w_a <= 64'd0;
			cfg_q.mat_w_b <= 64'd65536 << 32;
			cfg_q.width <= VW'(640);
			cfg_q.height <= VW'(480);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAT_X_A: cfg_q.mat_x_a <= cfg_data;
				REG_MAT_X_B: cfg_q.mat_x_b <= cfg_data;
				REG_MAT_Y_A: cfg_q.mat_y_a <= cfg_data;
				REG_MAT_Y_B: cfg_q.mat_y_b <= cfg_data;
				REG_MAT_W_A: cfg_q.mat_w_a <= cfg_data;
				REG_MAT_W_B: cfg_q.mat_w_b <= cfg_data;
				REG_WIDTH:   cfg_q.width <= cfg_data[VW-1:0];
				REG_HEIGHT:  cfg_q.height <= cfg_data[VW-1:0];
				default: ;
			endcase
		end
	end

	// The front moves unless its last stage holds a point the queue cannot take.
	assign front_en = !f_valid || !q_full;
	assign s_axis_tready = front_en;
	assign q_push = f_valid && !q_full;

	// The back moves whenever the output register is free or being drained.
	assign back_en = !m_axis_tvalid || m_axis_tready;
	assign q_pop = back_en && !q_empty;

	vpts_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.en(front_en),
		.in_valid(s_axis_tvalid),
		.world_x(s_axis_tdata[31:0]),
		.world_y(s_axis_tdata[63:32]),
		.world_z(s_axis_tdata[95:64]),
		.out_valid(f_valid),
		.out_item(f_item)
	);

	vpts_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(f_item),
		.pop(q_pop),
		.full(q_full),
		.empty(q_empty),
		.pop_item(q_item)
	);

	vpts_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.width(cfg_q.width),
		.height(cfg_q.height),
		.en(back_en),
		.in_valid(!q_empty),
		.in_item(q_item),
		.out_valid(m_axis_tvalid),
		.on_screen(m_axis_tuser),
		.screen_x(sx),
		.screen_y(sy)
	);

	assign m_axis_tdata = {6'd0, sy, sx};

endmodule

>>> bench/vpts_checker.sv
// Watches the input, output and configuration channels of the projection block.
// Each accepted point is projected here, and the screen position is queued.
// Each accepted output request is compared with the oldest queued position.
module vpts_checker import vpts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [95:0] s_axis_tdata, // world_x, world_y, world_z
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [47:0] m_axis_tdata, // screen_x, screen_y, zero fill
	input  logic m_axis_tuser, // on_screen
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic on_screen;
		logic [20:0] screen_x;
		logic [20:0] screen_y;
	} pixel_t;

	typedef logic signed [127:0] wide_t;

	logic [63:0] mat [6];
	logic [VW-1:0] view_w;
	logic [VW-1:0] view_h;
	pixel_t pixels_due [$];

	function automatic wide_t sext(input logic [31:0] v);
		wide_t r;
		r = $signed(v);
		return r;
	endfunction

	// One matrix row against (x, y, z, 1.0), kept exact.
	function automatic wide_t row_dot(input logic [63:0] ra, input logic [63:0] rb,
			input wide_t px, input wide_t py, input wide_t pz);
		return sext(ra[31:0]) * px + sext(ra[63:32]) * py + sext(rb[31:0]) * pz
			+ sext(rb[63:32]) * 128'sd65536;
	endfunction

	function automatic pixel_t project(input logic [95:0] pt);
		wide_t px, py, pz, cx, cy, cw, nx, ny;
		pixel_t r;
		px = sext(pt[31:0]);
		py = sext(pt[63:32]);
		pz = sext(pt[95:64]);
		cx = row_dot(mat[0], mat[1], px, py, pz);
		cy = row_dot(mat[2], mat[3], px, py, pz);
		cw = row_dot(mat[4], mat[5], px, py, pz);
		r = '0;
		// Behind the camera, or outside the view bounds, gives a zero result.
		if (cw <= 0 || cx > cw || -cx > cw || cy > cw || -cy > cw)
			return r;
		nx = (cx + cw) * (wide_t'(view_w) * 128);
		ny = (cw - cy) * (wide_t'(view_h) * 128);
		r.on_screen = 1'b1;
		r.screen_x = 21'(nx / cw);
		r.screen_y = 21'(ny / cw);
		return r;
	endfunction

	task automatic report(input string what, input logic [20:0] got, input logic [20:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	assign pending = pixels_due.size();

	// Signals are settled at the falling edge; a request seen here is taken at the next rise.
	always @(negedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			mat[REG_MAT_X_A] = 64'd65536;
			mat[REG_MAT_X_B] = 64'd0;
			mat[REG_MAT_Y_A] = 64'd65536 << 32;
			mat[REG_MAT_Y_B] = 64'd0;
			mat[REG_MAT_W_A] = 64'd0;
			mat[REG_MAT_W_B] = 64'd65536 << 32;
			view_w = 13'd640;
			view_h = 13'd480;
			pixels_due.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH)
					view_w = cfg_data[VW-1:0];
				else if (cfg_index == REG_HEIGHT)
					view_h = cfg_data[VW-1:0];
				else
					mat[cfg_index] = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready)
				pixels_due.push_back(project(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (pixels_due.size() == 0) begin
					$display("unexpected output request at %0t", $time);
					errors++;
				end else begin
					want = pixels_due.pop_front();
					if (m_axis_tuser !== want.on_screen)
						report("on_screen", 21'(m_axis_tuser), 21'(want.on_screen));
					if (m_axis_tdata[20:0] !== want.screen_x)
						report("screen_x", m_axis_tdata[20:0], want.screen_x);
					if (m_axis_tdata[41:21] !== want.screen_y)
						report("screen_y", m_axis_tdata[41:21], want.screen_y);
				end
			end
		end
	end

endmodule

>>> bench/tb_vertex_project_to_screen.sv
module tb_vertex_project_to_screen;
	import vpts_pkg::*;

	localparam int LIMIT = 2000000;
	localparam int DRAIN = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0; // world_x, world_y, world_z
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata; // screen_x, screen_y, zero fill
	logic m_axis_tuser; // on_screen
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = REG_MAT_X_A;
	logic [63:0] cfg_data = '0;
	int errors;
	int pending;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_off = 1'b0;
	logic hold_go = 1'b0;

	vertex_project_to_screen uut (.*);

	vpts_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver readiness, with random stalls and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
		end
	end

	// The long hold-off lets the block fill up and push back on its input.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout");
			$display("== FAIL ==");
			$finish;
		end
	end

	// Writes all registers back to back, with valid held high throughout.
	task automatic write_regs(input logic [63:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(negedge clk);
			while (!cfg_ready) @(negedge clk);
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x};
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [31:0] spread(input logic [31:0] lim);
		return 32'(longint'($urandom_range(0, 32'(2 * longint'(lim)))) - longint'(lim));
	endfunction

	// Random point; most are in the frustum when w follows z.
	task automatic send_random();
		logic [31:0] z;
		if ($urandom_range(99) < 25) begin
			send_point($urandom, $urandom, $urandom);
		end else begin
			z = $urandom_range(1, 32'h7fffffff);
			if ($urandom_range(3) == 0)
				z = $urandom_range(1, 32'h00040000);
			send_point(spread(z), spread(z), z);
		end
	endtask

	initial begin
		logic [63:0] regs [8];
		int mode;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default identity view: w is the constant 1.0.
		send_point(32'd0, 32'd0, 32'd0);
		send_point(32'h00010000, 32'h00010000, 32'h7fffffff);
		send_point(32'hffff0000, 32'hffff0000, 32'h80000000);
		send_point(32'h00010001, 32'd0, 32'd0);
		send_point(32'd0, 32'hfffeffff, 32'd0);
		send_point(32'h7fffffff, 32'h80000000, 32'hffffffff);
		send_point(32'h00008000, 32'hffff8000, 32'h12345678);
		s_axis_tvalid <= 1'b0;
		wait_idle();

		for (int phase = 0; phase < 8; phase++) begin
			mode = phase % 4;
			// Perspective rows: x and y straight through, w taken from z.
			regs[REG_MAT_X_A] = 64'd65536;
			regs[REG_MAT_X_B] = 64'd0;
			regs[REG_MAT_Y_A] = 64'd65536 << 32;
			regs[REG_MAT_Y_B] = 64'd0;
			regs[REG_MAT_W_A] = 64'd0;
			regs[REG_MAT_W_B] = 64'd65536;
			regs[REG_WIDTH] = 64'($urandom_range(1, 4096));
			regs[REG_HEIGHT] = 64'($urandom_range(1, 4096));
			case (phase)
				1: begin
					regs[REG_WIDTH] = 64'd4096;
					regs[REG_HEIGHT] = 64'd1;
				end
				2: begin
					for (int i = 0; i < 6; i++)
						regs[i] = {$urandom, $urandom};
					regs[REG_WIDTH] = 64'd8191;
					regs[REG_HEIGHT] = 64'd0;
				end
				3: begin
					regs[REG_MAT_X_A] = 64'h80000000_80000000;
					regs[REG_MAT_Y_A] = 64'h7fffffff_7fffffff;
					regs[REG_MAT_W_A] = 64'h7fffffff_80000000;
					regs[REG_MAT_W_B] = 64'h7fffffff_7fffffff;
					regs[REG_WIDTH] = 64'd1;
					regs[REG_HEIGHT] = 64'd4096;
				end
				5: begin
					regs[REG_MAT_X_A] = 64'd32768;
					regs[REG_MAT_Y_A] = 64'hffff0000_00000000;
					regs[REG_MAT_X_B] = 64'h00000100_00000000;
				end
				default: ;
			endcase
			write_regs(regs);
			idle_pct = (mode == 1) ? 52 : (mode == 3) ? 13 : 0;
			stall_pct = (mode == 2) ? 52 : (mode == 3) ? 13 : 0;
			if (phase == 4)
				hold_go = 1'b1;
			if (phase == 0) begin
				send_point(32'd0, 32'd0, 32'h00010000);
				send_point(32'h00010000, 32'h00010000, 32'h00010000);
				send_point(32'hffff0000, 32'hffff0000, 32'h00010000);
				send_point(32'd5, 32'd5, 32'd0);
				send_point(32'd0, 32'd0, 32'hffff0000);
				send_point(32'h00010001, 32'd0, 32'h00010000);
				send_point(32'd0, 32'hfffeffff, 32'h00010000);
				send_point(32'h7fffffff, 32'h80000001, 32'h7fffffff);
			end
			for (int n = 0; n < 230; n++)
				send_random();
			s_axis_tvalid <= 1'b0;
			wait_idle();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
sv/vpts_pkg.sv
sv/vpts_front.sv
sv/vpts_fifo.sv
sv/vpts_back.sv
sv/vertex_project_to_screen.sv
bench/vpts_checker.sv
bench/tb_vertex_project_to_screen.sv
